/* hdl/pulse_meter_command_responder_defines.svh */
// Assertion macros shared by the pulse meter command responder modules.
`ifndef PULSE_METER_COMMAND_RESPONDER_DEFINES_SVH
`define PULSE_METER_COMMAND_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
`define PMCR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PMCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PMCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PMCR_ASSERT(lbl, cond, msg)
`define PMCR_ASSERT_IMPL(lbl, ante, cons, msg)
`define PMCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/pmcr_pkg.sv */
package pmcr_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REQ_DEPTH = 2;

  localparam logic [VAL_W-1:0] PULSE_HOLDOFF_RESET   = 16'd781;
  localparam logic [VAL_W-1:0] RELEASE_HOLDOFF_RESET = 16'd156;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HOLDOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HOLDOFF = 2'd1;

  typedef enum logic [1:0] {
    CMD_TICK          = 2'd0,
    CMD_READ_INTERVAL = 2'd1,
    CMD_READ_COUNT    = 2'd2,
    CMD_UNKNOWN       = 2'd3
  } cmd_t;

  // One queued reply: either a number to print or the error text.
  typedef struct packed {
    logic             is_err;
    logic [VAL_W-1:0] value;
  } req_t;

  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] ERR_TEXT [3] = '{8'h45, 8'h52, 8'h52};

  // Multiples 0..9 of each decimal weight, from ten thousands down to tens.
  localparam logic [16:0] DEC_MULT [4][10] = '{
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
      17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
      17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
      17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
      17'd50, 17'd60, 17'd70, 17'd80, 17'd90}
  };

  // Decimal digit at the given weight, for a remainder below ten times it.
  function automatic logic [3:0] dec_digit(logic [VAL_W-1:0] x, logic [1:0] pw);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, x} >= DEC_MULT[pw][k]) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

/* hdl/pulse_meter_command_responder.sv */
// Pulse meter with a text command responder.
// Input channel: in_command and in_sensor_low are taken at an edge where in_push is high
// and in_full is low. Tick items (command 0) update the interval timer, holdoff and pulse
// count in that same cycle and produce nothing; one tick can be taken every clock while in_full is low.
// Commands 1 (read interval), 2 (read and clear count) and 3 (unknown) take a snapshot
// at acceptance and place it in a two-entry request queue; in_full is high while that
// queue is full, and then no item of any kind is taken.
// Result channel: one item per reply character on out_reply_char, out_last high on the
// closing carriage return; out_empty low means an item waits, out_pop takes it.
// The emitter produces one decimal digit per cycle, while the output register can take
// it, from a table of weight multiples; a reply runs at one character per cycle
// while out_pop is held high.
// When the receiver stalls, the character is held in the output register, the emitter
// waits, the request queue fills, and in_full then holds off further items.
// cfg_index 0 writes the pulse holdoff, 1 the release holdoff; cfg_ready is always high.
// Reset (rst_n low at a clock edge) empties both queues, clears timer, interval, count,
// lock and holdoff, and loads the holdoff registers with 781 and 156 ticks.
module pulse_meter_command_responder #(
  parameter int unsigned REQ_DEPTH = pmcr_pkg::REQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [1:0]                     in_command,
  input  logic                           in_sensor_low,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_reply_char,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmcr_pkg::VAL_W-1:0]     cfg_data
);

  logic           req_push, req_full, req_pop, req_empty;
  pmcr_pkg::req_t req_data, req_head;

  pmcr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_command    (in_command),
    .in_sensor_low (in_sensor_low),
    .in_full       (in_full),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cfg_ready     (cfg_ready),
    .req_full      (req_full),
    .req_push      (req_push),
    .req_data      (req_data)
  );

  pmcr_reqq #(
    .DEPTH (REQ_DEPTH)
  ) u_reqq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (req_data),
    .full      (req_full),
    .pop       (req_pop),
    .empty     (req_empty),
    .head      (req_head)
  );

  pmcr_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_empty      (req_empty),
    .req_head       (req_head),
    .req_pop        (req_pop),
    .out_empty      (out_empty),
    .out_reply_char (out_reply_char),
    .out_last       (out_last),
    .out_pop        (out_pop)
  );

endmodule

/* hdl/pmcr_front.sv */
`include "pulse_meter_command_responder_defines.svh"

module pmcr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [1:0]                     in_command,
  input  logic                           in_sensor_low,
  output logic                           in_full,
  input  logic                           cfg_valid,
  input  logic [pmcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmcr_pkg::VAL_W-1:0]     cfg_data,
  output logic                           cfg_ready,
  input  logic                           req_full,
  output logic                           req_push,
  output pmcr_pkg::req_t                 req_data
);

  logic [pmcr_pkg::VAL_W-1:0] pulse_holdoff_r, release_holdoff_r;
  logic [pmcr_pkg::VAL_W-1:0] timer_r, timer_nxt;
  logic [pmcr_pkg::VAL_W-1:0] interval_r, interval_nxt;
  logic [pmcr_pkg::VAL_W-1:0] count_r, count_nxt;
  logic [pmcr_pkg::VAL_W-1:0] holdoff_r, holdoff_nxt;
  logic                       locked_r, locked_nxt;
  logic [pmcr_pkg::VAL_W-1:0] timer_inc;
  logic                       accept;
  pmcr_pkg::cmd_t             cmd;

  assign cmd       = pmcr_pkg::cmd_t'(in_command);
  assign in_full   = req_full;
  assign accept    = in_push && !req_full;
  assign cfg_ready = 1'b1;
  assign timer_inc = timer_r + 1'b1;

  always_comb begin
    timer_nxt    = timer_r;
    interval_nxt = interval_r;
    count_nxt    = count_r;
    holdoff_nxt  = holdoff_r;
    locked_nxt   = locked_r;
    req_push     = 1'b0;
    req_data     = '{is_err: 1'b0, value: interval_r};
    if (accept) begin
      unique case (cmd)
        pmcr_pkg::CMD_TICK: begin
          timer_nxt = timer_inc;
          if (holdoff_r != '0) begin
            holdoff_nxt = holdoff_r - 1'b1;
          end else if (in_sensor_low) begin
            if (!locked_r) begin
              count_nxt    = count_r + 1'b1;
              interval_nxt = timer_inc;
              timer_nxt    = '0;
              locked_nxt   = 1'b1;
              holdoff_nxt  = pulse_holdoff_r;
            end
          end else begin
            locked_nxt  = 1'b0;
            holdoff_nxt = release_holdoff_r;
          end
        end
        pmcr_pkg::CMD_READ_INTERVAL: begin
          req_push = 1'b1;
        end
        pmcr_pkg::CMD_READ_COUNT: begin
          req_push       = 1'b1;
          req_data.value = count_r;
          count_nxt      = '0;
        end
        default: begin
          req_push        = 1'b1;
          req_data.is_err = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_holdoff_r   <= pmcr_pkg::PULSE_HOLDOFF_RESET;
      release_holdoff_r <= pmcr_pkg::RELEASE_HOLDOFF_RESET;
      timer_r           <= '0;
      interval_r        <= '0;
      count_r           <= '0;
      holdoff_r         <= '0;
      locked_r          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pmcr_pkg::REG_PULSE_HOLDOFF) begin
          pulse_holdoff_r <= cfg_data;
        end else if (cfg_index == pmcr_pkg::REG_RELEASE_HOLDOFF) begin
          release_holdoff_r <= cfg_data;
        end
      end
      timer_r    <= timer_nxt;
      interval_r <= interval_nxt;
      count_r    <= count_nxt;
      holdoff_r  <= holdoff_nxt;
      locked_r   <= locked_nxt;
    end
  end

  `PMCR_ASSERT_NEXT(a_count_cleared, accept && cmd == pmcr_pkg::CMD_READ_COUNT, count_r == '0, "count not cleared after read")
  `PMCR_ASSERT_IMPL(a_tick_no_reply, accept && cmd == pmcr_pkg::CMD_TICK, !req_push, "tick item queued a reply")

endmodule

/* hdl/pmcr_reqq.sv */
`include "pulse_meter_command_responder_defines.svh"

module pmcr_reqq #(
  parameter int unsigned DEPTH = pmcr_pkg::REQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pmcr_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pmcr_pkg::req_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pmcr_pkg::req_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `PMCR_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "request queue popped while empty")

endmodule

/* hdl/pmcr_emit.sv */
`include "pulse_meter_command_responder_defines.svh"

module pmcr_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_empty,
  input  pmcr_pkg::req_t req_head,
  output logic           req_pop,
  output logic           out_empty,
  output logic [7:0]     out_reply_char,
  output logic           out_last,
  input  logic           out_pop
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_ONES,
    ST_CR,
    ST_ERR
  } state_t;

  state_t                     state_r, state_nxt;
  logic [pmcr_pkg::VAL_W-1:0] x_r, x_nxt;
  logic [1:0]                 idx_r, idx_nxt;
  logic                       started_r, started_nxt;
  logic                       ov_r, ov_nxt;
  logic [7:0]                 char_r, char_nxt;
  logic                       last_r, last_nxt;
  logic                       step;
  logic [3:0]                 digit;
  logic [16:0]                digit_weight;

  // The output register takes a new item when it is empty or being drained.
  assign step           = !ov_r || out_pop;
  assign digit          = pmcr_pkg::dec_digit(x_r, idx_r);
  assign digit_weight   = pmcr_pkg::DEC_MULT[idx_r][digit];
  assign out_empty      = !ov_r;
  assign out_reply_char = char_r;
  assign out_last       = last_r;

  always_comb begin
    state_nxt   = state_r;
    x_nxt       = x_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    ov_nxt      = step ? 1'b0 : ov_r;
    char_nxt    = char_r;
    last_nxt    = last_r;
    req_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!req_empty) begin
          req_pop     = 1'b1;
          x_nxt       = req_head.value;
          idx_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = req_head.is_err ? ST_ERR : ST_DEC;
        end
      end
      ST_DEC: begin
        if (step) begin
          x_nxt = x_r - digit_weight[pmcr_pkg::VAL_W-1:0];
          // Leading zeros are dropped until the first nonzero digit.
          if (digit != 4'd0 || started_r) begin
            ov_nxt      = 1'b1;
            char_nxt    = pmcr_pkg::DIGIT_BASE + {4'd0, digit};
            last_nxt    = 1'b0;
            started_nxt = 1'b1;
          end
          if (idx_r == 2'd3) begin
            state_nxt = ST_ONES;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_ONES: begin
        if (step) begin
          ov_nxt    = 1'b1;
          char_nxt  = pmcr_pkg::DIGIT_BASE + {4'd0, x_r[3:0]};
          last_nxt  = 1'b0;
          state_nxt = ST_CR;
        end
      end
      ST_CR: begin
        if (step) begin
          ov_nxt    = 1'b1;
          char_nxt  = pmcr_pkg::CHAR_CR;
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (step) begin
          ov_nxt   = 1'b1;
          char_nxt = pmcr_pkg::ERR_TEXT[idx_r];
          last_nxt = 1'b0;
          if (idx_r == 2'd2) begin
            state_nxt = ST_CR;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ov_r      <= 1'b0;
      idx_r     <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
    end
    x_r    <= x_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  `PMCR_ASSERT_IMPL(a_last_is_cr, !out_empty && out_last, out_reply_char == pmcr_pkg::CHAR_CR, "last item is not a carriage return")
  `PMCR_ASSERT_IMPL(a_pop_in_idle, req_pop, state_r == ST_IDLE, "request taken while a reply is in progress")

endmodule
